// ===== rtl/cdad_pkg.sv =====
// Shared types, constants and calendar functions for the date adder.
`default_nettype none

package cdad_pkg;

  // Field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DAYS_W   = 16;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 14;
  localparam int TDATA_W  = 24;
  // Working year is one bit wider so an overrun past the top year is visible
  localparam int YACC_W   = 15;
  localparam int MODSEL_W = 3;
  localparam int DOY_W    = 9;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_BASE_YEAR  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_BASE_MONTH = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BASE_DAY   = 2'd2;

  // Calendar constants
  localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd16383;
  localparam logic [31:0]        ERA_DAYS     = 32'd146097;
  localparam logic [YACC_W-1:0]  ERA_YEARS    = 15'd400;
  localparam logic [YEAR_W-1:0]  CYCLE_LAST   = 14'd399;
  localparam logic [31:0]        CYCLE_YEARS  = 32'd400;
  localparam logic [MODSEL_W-1:0] MOD_TOP_SEL = 3'd5;
  localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_INIT,
    ST_ERA,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic                mod_step;
    logic [MODSEL_W-1:0] mod_sel;
    logic                init;
    logic                era_step;
    logic                year_step;
    logic                month_step;
    logic                finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad;
    logic era_ge;
    logic year_ge;
    logic month_ge;
    logic over;
  } status_t;

  // Leap test from the year's position in the 400-year cycle
  function automatic logic is_leap(input logic [YEAR_W-1:0] ycyc);
    return (ycyc[1:0] == 2'b00) && (ycyc != 14'd100) && (ycyc != 14'd200) &&
           (ycyc != 14'd300);
  endfunction

  // Month length, zero for a month code outside January to December
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd0;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        len = 5'd31;
      default:                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] cum;
    cum = 9'd0;
    case (m)
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    if (leap && (m > MONTH_FEB) && (m <= MONTH_DEC)) begin
      cum = cum + 9'd1;
    end
    return cum;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cdad_ctrl.sv =====
// Sequencer for the date adder: reduce, align, then era, year and month steps.
`default_nettype none

module cdad_ctrl
  import cdad_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    out_free,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         idle
);

  state_t              state_r, state_nxt;
  logic [MODSEL_W-1:0] sel_r, sel_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.mod_sel = sel_r;
    idle        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          cmd.load  = 1'b1;
          sel_nxt   = MOD_TOP_SEL;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sel_r == '0) begin
          state_nxt = ST_INIT;
        end else begin
          sel_nxt = sel_r - 3'd1;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = status.bad ? ST_DONE : ST_ERA;
      end
      ST_ERA: begin
        if (status.over) begin
          state_nxt = ST_DONE;
        end else if (status.era_ge) begin
          cmd.era_step = 1'b1;
        end else begin
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (status.over) begin
          state_nxt = ST_DONE;
        end else if (status.year_ge) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (status.month_ge) begin
          cmd.month_step = 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cdad_dpath.sv =====
// Datapath for the date adder: day remainder, year, month and cycle position.
`default_nettype none

module cdad_dpath
  import cdad_pkg::*;
#(
  parameter int DAY_COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire cmd_t               cmd,
  input  wire logic [DAYS_W-1:0]  days_ahead,
  input  wire logic [YEAR_W-1:0]  base_year,
  input  wire logic [MONTH_W-1:0] base_month,
  input  wire logic [DAY_W-1:0]   base_day,
  output status_t                 status,
  output logic [YEAR_W-1:0]       result_year,
  output logic [MONTH_W-1:0]      result_month,
  output logic [DAY_W-1:0]        result_day,
  output logic                    bad_base
);

  // Remainder holds the span plus the base day of year
  localparam int RW = DAY_COUNT_BITS + 2;

  logic [RW-1:0]      rem_r, rem_nxt;
  logic [YACC_W-1:0]  year_r, year_nxt;
  logic [YEAR_W-1:0]  cyc_r, cyc_nxt;
  logic [MONTH_W-1:0] mon_r, mon_nxt;
  logic               bad_r, bad_nxt;

  logic [31:0]        span;
  logic [31:0]        rem_ext;
  logic [31:0]        mod_sub;
  logic               leap;
  logic [DAY_W-1:0]   base_len;
  logic [DAY_W-1:0]   cur_len;
  logic [31:0]        year_len;
  logic               base_bad;

  assign span     = 32'(days_ahead) & ((32'd1 << DAY_COUNT_BITS) - 32'd1);
  assign rem_ext  = 32'(rem_r);
  assign mod_sub  = CYCLE_YEARS << cmd.mod_sel;
  assign leap     = is_leap(cyc_r);
  assign base_len = month_len(base_month, leap);
  assign cur_len  = month_len(mon_r, leap);
  assign year_len = leap ? 32'd366 : 32'd365;
  assign base_bad = (base_year == '0) || (base_len == '0) || (base_day == '0) ||
                    (base_day > base_len);

  // Status to the sequencer
  always_comb begin
    status.bad      = base_bad;
    status.era_ge   = rem_ext >= ERA_DAYS;
    status.year_ge  = rem_ext >= year_len;
    status.month_ge = rem_ext >= 32'(cur_len);
    status.over     = year_r > YACC_W'(YEAR_MAX);
  end

  // Register updates per command
  always_comb begin
    rem_nxt  = rem_r;
    year_nxt = year_r;
    cyc_nxt  = cyc_r;
    mon_nxt  = mon_r;
    bad_nxt  = bad_r;
    if (cmd.load) begin
      rem_nxt  = RW'(span);
      year_nxt = YACC_W'(base_year);
      cyc_nxt  = base_year;
      mon_nxt  = MONTH_JAN;
      bad_nxt  = 1'b0;
    end
    // Restoring reduction of the year modulo 400
    if (cmd.mod_step && (32'(cyc_r) >= mod_sub)) begin
      cyc_nxt = YEAR_W'(32'(cyc_r) - mod_sub);
    end
    // Rebase to the first of January of the base year
    if (cmd.init) begin
      bad_nxt = base_bad;
      rem_nxt = RW'(rem_ext + 32'(days_before(base_month, leap)) + 32'(base_day) - 32'd1);
    end
    // Whole 400-year cycles leave the cycle position unchanged
    if (cmd.era_step) begin
      rem_nxt  = RW'(rem_ext - ERA_DAYS);
      year_nxt = year_r + ERA_YEARS;
    end
    if (cmd.year_step) begin
      rem_nxt  = RW'(rem_ext - year_len);
      year_nxt = year_r + 15'd1;
      cyc_nxt  = (cyc_r == CYCLE_LAST) ? '0 : cyc_r + 14'd1;
    end
    if (cmd.month_step) begin
      rem_nxt = RW'(rem_ext - 32'(cur_len));
      mon_nxt = mon_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    year_r <= year_nxt;
    cyc_r  <= cyc_nxt;
    mon_r  <= mon_nxt;
    bad_r  <= bad_nxt;
  end

  // Result selection: invalid base, saturated, or the stepped date
  always_comb begin
    bad_base = bad_r;
    if (bad_r) begin
      result_year  = '0;
      result_month = '0;
      result_day   = '0;
    end else if (status.over) begin
      result_year  = YEAR_MAX;
      result_month = MONTH_DEC;
      result_day   = DAY_LAST_DEC;
    end else begin
      result_year  = year_r[YEAR_W-1:0];
      result_month = mon_r;
      result_day   = DAY_W'(rem_ext + 32'd1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/calendar_date_add_days.sv =====
// Top level of the date adder: base date registers, output register, sequencer and datapath.
//
//  Channel  Direction  Content
//  in_      slave      tdata[15:0] days_ahead
//  out_     master     tdata: result_year, result_month, result_day; tuser: bad_base
//  cfg_     slave      cfg_index 0 base_year, 1 base_month, 2 base_day
//
// One request at a time. After the input transfer a request passes through the accept state,
// the reduction of the base year to its place in the 400-year cycle, a rebase state, E 400-year
// steps, Y year steps (up to about 180 for a 16-bit count), M month steps (at most 11), an exit
// from each of the three step loops and a handoff; out_tvalid then rises from the output register.
// An invalid base or a year past the top skips the remaining loops. A finished result
// waits in the output register while the next request is taken; the one after that holds
// in handoff until the register frees. Reset gives base date 2000-01-01, empty output.
`default_nettype none

module calendar_date_add_days
  import cdad_pkg::*;
#(
  parameter int DAY_COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Request channel
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [DAYS_W-1:0]  in_tdata,   // [15:0] days_ahead
  // Result channel
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // [13:0] year, [17:14] month, [22:18] day, [23] 0
  output logic                    out_tuser,  // [0] bad_base
  // Configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDATA_W-1:0] cfg_data
);

  logic [YEAR_W-1:0]  base_year_r;
  logic [MONTH_W-1:0] base_month_r;
  logic [DAY_W-1:0]   base_day_r;
  logic               out_valid_r;
  logic [TDATA_W-1:0] out_data_r;
  logic               out_user_r;

  cmd_t               cmd;
  status_t            status;
  logic               idle;
  logic               out_free;
  logic [YEAR_W-1:0]  res_year;
  logic [MONTH_W-1:0] res_month;
  logic [DAY_W-1:0]   res_day;
  logic               res_bad;

  assign cfg_ready  = 1'b1;
  assign in_tready  = idle;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Base date registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_year_r  <= 14'd2000;
      base_month_r <= 4'd1;
      base_day_r   <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_YEAR:  base_year_r  <= cfg_data;
        REG_BASE_MONTH: base_month_r <= cfg_data[MONTH_W-1:0];
        REG_BASE_DAY:   base_day_r   <= cfg_data[DAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= {1'b0, res_day, res_month, res_year};
      out_user_r <= res_bad;
    end
  end

  cdad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_tvalid),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .idle     (idle)
  );

  cdad_dpath #(
    .DAY_COUNT_BITS (DAY_COUNT_BITS)
  ) u_dpath (
    .clk          (clk),
    .cmd          (cmd),
    .days_ahead   (in_tdata),
    .base_year    (base_year_r),
    .base_month   (base_month_r),
    .base_day     (base_day_r),
    .status       (status),
    .result_year  (res_year),
    .result_month (res_month),
    .result_day   (res_day),
    .bad_base     (res_bad)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for calendar_date_add_days: directed table, random phases, scoreboard.
module tb_top;
  import cdad_pkg::*;

  localparam int IDLE_LIMIT  = 5000;  // cycles without any transfer before giving up
  localparam int HOLD_CYCLES = 800;   // long result back-pressure stretch
  localparam int TAIL_CYCLES = 250;   // about one worst-case request latency
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 100;
  localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, writes are dropped

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               bad;
  } date_res_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [CIDX_W-1:0]  idx;
    logic [CDATA_W-1:0] data;
    logic [DAYS_W-1:0]  days;
    bit                 pinned;
    date_res_t          want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [DAYS_W-1:0]  in_tdata;    // [15:0] days_ahead
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;   // [13:0] year, [17:14] month, [22:18] day, [23] pad
  logic               out_tuser;   // [0] bad_base
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_data;

  // Base date as the block should hold it
  logic [YEAR_W-1:0]  base_year_m;
  logic [MONTH_W-1:0] base_month_m;
  logic [DAY_W-1:0]   base_day_m;

  date_res_t pending_dates[$];
  int errors = 0;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_asks;

  wire any_xfer = (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                  (cfg_valid && cfg_ready);

  calendar_date_add_days dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------- calendar arithmetic ----------------

  function automatic bit is_leap_year(longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned month_days(longint unsigned m, longint unsigned y);
    if (m == 2) return is_leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m >= 1 && m <= 12) return 31;
    return 0;
  endfunction

  // Day count from 1 March of year 0 (years start in March so the leap day is last)
  function automatic longint unsigned ordinal_of(longint unsigned y, longint unsigned m,
                                                 longint unsigned d);
    longint unsigned ys, era, yoe, mp, doy;
    ys  = (m <= 2) ? y - 1 : y;
    era = ys / 400;
    yoe = ys - era * 400;
    mp  = (m + 9) % 12;
    doy = (153 * mp + 2) / 5 + d - 1;
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
  endfunction

  function automatic void date_of_ordinal(longint unsigned z, output longint unsigned y,
                                          output longint unsigned m, output longint unsigned d);
    longint unsigned era, doe, yoe, doy, mp;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    d   = doy - (153 * mp + 2) / 5 + 1;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  // Expected date for a request against the current base date
  function automatic date_res_t predict_date(logic [DAYS_W-1:0] days);
    longint unsigned len, y, m, d;
    date_res_t r;
    r = '0;
    len = month_days(base_month_m, base_year_m);
    if (base_year_m == 0 || len == 0 || base_day_m == 0 || base_day_m > len) begin
      r.bad = 1'b1;
      return r;
    end
    date_of_ordinal(ordinal_of(base_year_m, base_month_m, base_day_m) + days, y, m, d);
    // past the top year the block pins to the last representable day
    if (y > YEAR_MAX) begin
      y = YEAR_MAX;
      m = MONTH_DEC;
      d = DAY_LAST_DEC;
    end
    r.year  = y[YEAR_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.day   = d[DAY_W-1:0];
    return r;
  endfunction

  function automatic void apply_cfg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
    case (idx)
      REG_BASE_YEAR:  base_year_m  = data[YEAR_W-1:0];
      REG_BASE_MONTH: base_month_m = data[MONTH_W-1:0];
      REG_BASE_DAY:   base_day_m   = data[DAY_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------- stimulus table rows ----------------

  function automatic stim_row_t cfg_row(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
    stim_row_t r;
    r.kind = ROW_CFG;  r.idx = idx;  r.data = data;
    r.days = '0;  r.pinned = 1'b0;  r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t req_row(logic [DAYS_W-1:0] days);
    stim_row_t r;
    r.kind = ROW_REQ;  r.idx = '0;  r.data = '0;
    r.days = days;  r.pinned = 1'b0;  r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t pin_row(logic [DAYS_W-1:0] days, int y, int m, int d, bit bad);
    stim_row_t r;
    r = req_row(days);
    r.pinned     = 1'b1;
    r.want.year  = y[YEAR_W-1:0];
    r.want.month = m[MONTH_W-1:0];
    r.want.day   = d[DAY_W-1:0];
    r.want.bad   = bad;
    return r;
  endfunction

  // ---------------- drivers (change on the falling edge) ----------------

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
    in_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, data);
    @(negedge clk);
  endtask

  task automatic send_days(logic [DAYS_W-1:0] days, bit pinned, date_res_t want);
    cfg_valid = 1'b0;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_tvalid = 1'b1;
    in_tdata  = days;
    do @(posedge clk); while (!in_tready);
    pending_dates.push_back(pinned ? want : predict_date(days));
    @(negedge clk);
  endtask

  // Block is idle once every queued date has come back (one result per request)
  task automatic drain();
    in_tvalid = 1'b0;
    cfg_valid = 1'b0;
    while (pending_dates.size() != 0) @(negedge clk);
  endtask

  // ---------------- result side ----------------

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen  = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Compare each result transfer against the oldest queued date
  always @(posedge clk) begin
    date_res_t got;
    date_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.year  = out_tdata[YEAR_W-1:0];
      got.month = out_tdata[YEAR_W+MONTH_W-1:YEAR_W];
      got.day   = out_tdata[YEAR_W+MONTH_W+DAY_W-1:YEAR_W+MONTH_W];
      got.bad   = out_tuser;
      if (pending_dates.size() == 0) begin
        $error("result with nothing pending: %0d-%0d-%0d bad %0d",
               got.year, got.month, got.day, got.bad);
        errors++;
      end else begin
        want = pending_dates.pop_front();
        if (got.year != want.year) begin
          $error("result_year: expected %0d, got %0d", want.year, got.year);
          errors++;
        end
        if (got.month != want.month) begin
          $error("result_month: expected %0d, got %0d", want.month, got.month);
          errors++;
        end
        if (got.day != want.day) begin
          $error("result_day: expected %0d, got %0d", want.day, got.day);
          errors++;
        end
        if (got.bad != want.bad) begin
          $error("bad_base: expected %0d, got %0d", want.bad, got.bad);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without a single transfer on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (any_xfer) quiet = 0;
      else quiet++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // ---------------- main sequence ----------------

  initial begin
    stim_row_t          rows[$];
    int                 sel;
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [CDATA_W-1:0] pad;
    logic [DAYS_W-1:0]  days;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_BASE_YEAR;
    cfg_data     = '0;
    tx_idle_pct  = 7;
    rx_idle_pct  = 56;
    hold_asks    = 0;
    base_year_m  = 14'd2000;
    base_month_m = 4'd1;
    base_day_m   = 5'd1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset base, leap February, unmapped index, invalid bases, range ends
    rows.push_back(pin_row(0, 2000, 1, 1, 0));
    rows.push_back(pin_row(1, 2000, 1, 2, 0));
    rows.push_back(pin_row(59, 2000, 2, 29, 0));
    rows.push_back(pin_row(60, 2000, 3, 1, 0));
    rows.push_back(pin_row(366, 2001, 1, 1, 0));
    rows.push_back(req_row(16'hFFFF));
    rows.push_back(cfg_row(REG_SPARE, 14'h3FFF));
    rows.push_back(pin_row(0, 2000, 1, 1, 0));
    rows.push_back(cfg_row(REG_BASE_YEAR, 1900));
    rows.push_back(cfg_row(REG_BASE_MONTH, 2));
    rows.push_back(cfg_row(REG_BASE_DAY, 28));
    rows.push_back(pin_row(1, 1900, 3, 1, 0));
    rows.push_back(cfg_row(REG_BASE_DAY, 29));          // 1900 is a plain century year
    rows.push_back(pin_row(5, 0, 0, 0, 1));
    rows.push_back(cfg_row(REG_BASE_YEAR, 2000));
    rows.push_back(pin_row(0, 2000, 2, 29, 0));
    rows.push_back(cfg_row(REG_BASE_YEAR, 0));
    rows.push_back(pin_row(7, 0, 0, 0, 1));
    rows.push_back(cfg_row(REG_BASE_YEAR, 1));
    rows.push_back(cfg_row(REG_BASE_MONTH, 1));
    rows.push_back(cfg_row(REG_BASE_DAY, 1));
    rows.push_back(pin_row(0, 1, 1, 1, 0));
    rows.push_back(req_row(16'hFFFF));
    rows.push_back(cfg_row(REG_BASE_MONTH, 0));
    rows.push_back(pin_row(0, 0, 0, 0, 1));
    rows.push_back(cfg_row(REG_BASE_MONTH, 13));
    rows.push_back(pin_row(0, 0, 0, 0, 1));
    rows.push_back(cfg_row(REG_BASE_MONTH, 14'h3FFF));  // month field reads 15
    rows.push_back(pin_row(0, 0, 0, 0, 1));
    rows.push_back(cfg_row(REG_BASE_MONTH, 4));
    rows.push_back(cfg_row(REG_BASE_DAY, 31));
    rows.push_back(pin_row(0, 0, 0, 0, 1));
    rows.push_back(cfg_row(REG_BASE_DAY, 0));
    rows.push_back(pin_row(0, 0, 0, 0, 1));
    rows.push_back(cfg_row(REG_BASE_YEAR, 9999));
    rows.push_back(cfg_row(REG_BASE_MONTH, 12));
    rows.push_back(cfg_row(REG_BASE_DAY, 31));
    rows.push_back(pin_row(1, 10000, 1, 1, 0));
    rows.push_back(req_row(16'hFFFF));
    rows.push_back(cfg_row(REG_BASE_YEAR, 14'h3FFF));
    rows.push_back(pin_row(0, 16383, 12, 31, 0));
    rows.push_back(pin_row(1, 16383, 12, 31, 0));       // saturates
    rows.push_back(cfg_row(REG_BASE_MONTH, 1));
    rows.push_back(cfg_row(REG_BASE_DAY, 1));
    rows.push_back(pin_row(16'hFFFF, 16383, 12, 31, 0));
    rows.push_back(cfg_row(REG_BASE_DAY, 14'h3FFF));    // day field reads 31
    rows.push_back(pin_row(0, 16383, 1, 31, 0));
    rows.push_back(cfg_row(REG_BASE_YEAR, 2100));
    rows.push_back(cfg_row(REG_BASE_MONTH, 2));
    rows.push_back(cfg_row(REG_BASE_DAY, 28));
    rows.push_back(req_row(1));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_days(rows[i].days, rows[i].pinned, rows[i].want);
      end
    end

    // Random phases: new base date each phase, then a burst of requests
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph < 5) begin
        tx_idle_pct = 7;
        rx_idle_pct = 56;
      end else if (ph < 10) begin
        tx_idle_pct = 56;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      sel = $urandom_range(0, 9);
      if (ph == 3 || ph == 11 || sel == 0) begin
        // raw register contents, often an invalid base
        y = YEAR_W'($urandom_range(0, 16383));
        m = MONTH_W'($urandom_range(0, 15));
        d = DAY_W'($urandom_range(0, 31));
      end else begin
        case (sel)
          6:       y = YEAR_W'($urandom_range(1, 450));
          7:       y = YEAR_W'(1700 + 100 * $urandom_range(0, 3));
          8:       y = YEAR_W'($urandom_range(10000, 16383));
          9:       y = YEAR_W'($urandom_range(16150, 16383));
          default: y = YEAR_W'($urandom_range(1, 9999));
        endcase
        m = MONTH_W'($urandom_range(1, 12));
        d = DAY_W'($urandom_range(1, 32'(month_days(m, y))));
      end
      // upper data bits beyond each field are ignored but still toggled
      pad = CDATA_W'($urandom);
      write_reg(REG_BASE_YEAR, y);
      write_reg(REG_BASE_MONTH, {pad[CDATA_W-1:MONTH_W], m});
      pad = CDATA_W'($urandom);
      write_reg(REG_BASE_DAY, {pad[CDATA_W-1:DAY_W], d});
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CDATA_W'($urandom));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((ph == 2 || ph == 12) && n == 50) hold_asks++;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
          days = DAYS_W'($urandom);
        end else if (sel < 7) begin
          days = DAYS_W'($urandom_range(0, 800));
        end else if (sel < 9) begin
          days = DAYS_W'($urandom_range(0, 40));
        end else begin
          case ($urandom_range(0, 3))
            0:       days = 0;
            1:       days = 16'hFFFF;
            2:       days = DAYS_W'(365 + $urandom_range(0, 1));
            default: days = 1461;
          endcase
        end
        send_days(days, 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
